// ===== design/imucf_pkg.sv =====
// Shared constants, angle table and sequencer states of the complementary attitude filter.
package imucf_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int TABLE_LEN        = 24;

	localparam logic [19:0] TIME_STEP_RESET = 20'd20972;

	// pi in Q2.30 (CORDIC angle accumulator), pi and 2*pi in Q16.16
	localparam logic signed [34:0] PI_Q30     = 35'sd3373259426;
	localparam logic signed [32:0] PI_Q16     = 33'sd205887;
	localparam logic signed [32:0] TWO_PI_Q16 = 33'sd411775;

	// blend weights, 0.98 truncated and its complement, in units of 2^-16
	localparam logic [16:0] GYRO_WEIGHT = 17'd64225;
	localparam logic [16:0] ACC_WEIGHT  = 17'd1311;

	// atan(2^-i) truncated to Q2.30
	function automatic logic [29:0] atan_q30(input logic [4:0] idx);
		logic [29:0] v;
		unique case (idx)
			5'd0:    v = 30'd843314856;
			5'd1:    v = 30'd497837829;
			5'd2:    v = 30'd263043836;
			5'd3:    v = 30'd133525158;
			5'd4:    v = 30'd67021686;
			5'd5:    v = 30'd33543515;
			5'd6:    v = 30'd16775850;
			5'd7:    v = 30'd8388437;
			5'd8:    v = 30'd4194282;
			5'd9:    v = 30'd2097149;
			5'd10:   v = 30'd1048575;
			5'd11:   v = 30'd524287;
			5'd12:   v = 30'd262143;
			5'd13:   v = 30'd131071;
			5'd14:   v = 30'd65535;
			5'd15:   v = 30'd32767;
			5'd16:   v = 30'd16383;
			5'd17:   v = 30'd8191;
			5'd18:   v = 30'd4095;
			5'd19:   v = 30'd2047;
			5'd20:   v = 30'd1023;
			5'd21:   v = 30'd511;
			5'd22:   v = 30'd255;
			5'd23:   v = 30'd127;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

	typedef enum logic [4:0] {
		ST_IDLE, ST_SQ_A, ST_SQ_B, ST_SQ_GO, ST_SQ_WAIT,
		ST_R_GO, ST_R_WAIT, ST_P_GO, ST_P_WAIT,
		ST_MUL_RX, ST_MUL_RY, ST_MUL_RZ, ST_MUL_BR1, ST_MUL_BR2,
		ST_MUL_BP1, ST_MUL_BP2, ST_FIN, ST_WB
	} state_t;

endpackage

// ===== design/imucf_isqrt.sv =====
// Bit-serial integer square root of (sum of squares) * 2^28, one result bit per cycle.
module imucf_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] sq,
	output logic        done,
	output logic [29:0] root
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [59:0] n_q;
	logic [31:0] rem_q;
	logic [29:0] root_q;

	logic [33:0] rem_sh;
	logic [33:0] trial;
	logic        ge;

	// one restoring step: bring down two radicand bits, try a one
	assign rem_sh = {rem_q, n_q[59:58]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign ge     = (rem_sh >= trial);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd29) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			n_q    <= {sq, 28'd0};
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			n_q    <= {n_q[57:0], 2'b00};
			rem_q  <= ge ? 32'(rem_sh - trial) : rem_sh[31:0];
			root_q <= {root_q[28:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ===== design/imucf_cordic.sv =====
// Iterative vectoring CORDIC giving atan2(y, x) in Q16.16, one rotation per cycle.
module imucf_cordic #(
	parameter int STEPS = imucf_pkg::CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [33:0] y_in,
	input  logic signed [33:0] x_in,
	output logic               done,
	output logic signed [20:0] angle
);

	localparam int RUNS = (STEPS > imucf_pkg::TABLE_LEN) ? imucf_pkg::TABLE_LEN : STEPS;

	logic               busy_q;
	logic               done_q;
	logic [4:0]         it_q;
	logic               zero_q;
	logic signed [33:0] x_q;
	logic signed [33:0] y_q;
	logic signed [34:0] z_q;

	logic signed [33:0] xs;
	logic signed [33:0] ys;
	logic signed [34:0] at;
	logic signed [34:0] zr;

	assign xs = x_q >>> it_q;
	assign ys = y_q >>> it_q;
	assign at = $signed({5'd0, imucf_pkg::atan_q30(it_q)});

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			it_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				it_q   <= '0;
			end else if (busy_q) begin
				it_q <= it_q + 5'd1;
				if (it_q == 5'(RUNS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: left half-plane folded onto the right with a pi offset
	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= (x_in == 34'sd0) && (y_in == 34'sd0);
			if (x_in[33]) begin
				x_q <= -x_in;
				y_q <= -y_in;
				z_q <= y_in[33] ? -imucf_pkg::PI_Q30 : imucf_pkg::PI_Q30;
			end else begin
				x_q <= x_in;
				y_q <= y_in;
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (y_q > 34'sd0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end
		end
	end

	// round Q2.30 to Q16.16
	assign zr    = z_q + 35'sd8192;
	assign angle = zero_q ? 21'sd0 : zr[34:14];
	assign done  = done_q;

endmodule

// ===== design/imu_complementary_attitude_filter.sv =====
// Top level of the complementary roll/pitch/yaw attitude filter.
// One transaction on the slave stream carries an IMU sample (or, with tuser set, a command
// that zeroes all three angles); each one yields exactly one transaction on the master
// stream with roll, pitch and yaw in Q16.16 radians. The block takes one sample at a time:
// an update runs through the bit-serial square root, two passes through the one shared
// CORDIC unit and nine products through the one shared multiplier; a reset command goes
// straight to the write-back state. The result sits in an output register, so a new
// sample is taken while it waits. time_step is written through the cfg channel, which is
// always ready.
module imu_complementary_attitude_filter #(
	parameter int CORDIC_STEPS = imucf_pkg::CORDIC_STEPS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// accel_x, accel_y, accel_z, rate_x, rate_y, rate_z
	input  logic [119:0] s_tdata,
	// command
	input  logic [0:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// roll_angle, pitch_angle, yaw_angle
	output logic [95:0]  m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [19:0]  cfg_data
);

	imucf_pkg::state_t state_q, state_d;

	logic [19:0]        ts_q;
	logic signed [15:0] ax_q, ay_q, az_q;
	logic signed [23:0] gx_q, gy_q, gz_q;
	logic signed [53:0] prod_q, acc_q;
	logic [29:0]        mag_q;
	logic signed [20:0] racc_q, pacc_q;
	logic signed [31:0] roll_q, pitch_q, yaw_q;
	logic signed [31:0] rint_q, pint_q;
	logic               m_tvalid_q;
	logic [95:0]        out_q;

	logic               accept;
	logic               load;
	logic signed [32:0] mul_a;
	logic signed [20:0] mul_b;
	logic signed [53:0] mul_p;
	logic               sq_start, sq_done;
	logic [29:0]        sq_root;
	logic               cor_start, cor_done;
	logic signed [33:0] cor_y, cor_x;
	logic signed [20:0] cor_angle;

	function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
		if (v > 38'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -38'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	// angle + round(rate * time_step / 2^20), saturated
	function automatic logic signed [31:0] integ(input logic signed [31:0] ang,
		input logic signed [53:0] p);
		logic signed [53:0] t;
		logic signed [37:0] s;
		t = p + 54'sd524288;
		s = 38'(ang) + 38'($signed(t[53:20]));
		return sat32(s);
	endfunction

	// (gyro term + accel term + 2^15) >> 16, saturated
	function automatic logic signed [31:0] blend(input logic signed [53:0] p1,
		input logic signed [53:0] p2);
		logic signed [53:0] v;
		v = p1 + p2 + 54'sd32768;
		return sat32(v[53:16]);
	endfunction

	// single 2*pi wrap of yaw
	function automatic logic signed [31:0] wrap(input logic signed [31:0] y);
		logic signed [32:0] e;
		logic signed [32:0] r;
		e = 33'(y);
		if (e > imucf_pkg::PI_Q16)
			r = e - imucf_pkg::TWO_PI_Q16;
		else if (e < -imucf_pkg::PI_Q16)
			r = e + imucf_pkg::TWO_PI_Q16;
		else
			r = e;
		return r[31:0];
	endfunction

	assign accept    = s_tvalid && s_tready;
	assign load      = (state_q == imucf_pkg::ST_WB) && (!m_tvalid_q || m_tready);
	assign cfg_ready = 1'b1;
	assign mul_p     = mul_a * mul_b;

	imucf_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.sq     (acc_q[31:0] + prod_q[31:0]),
		.done   (sq_done),
		.root   (sq_root)
	);

	imucf_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.y_in   (cor_y),
		.x_in   (cor_x),
		.done   (cor_done),
		.angle  (cor_angle)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			imucf_pkg::ST_IDLE:    if (accept) state_d = s_tuser[0] ? imucf_pkg::ST_WB
				: imucf_pkg::ST_SQ_A;
			imucf_pkg::ST_SQ_A:    state_d = imucf_pkg::ST_SQ_B;
			imucf_pkg::ST_SQ_B:    state_d = imucf_pkg::ST_SQ_GO;
			imucf_pkg::ST_SQ_GO:   state_d = imucf_pkg::ST_SQ_WAIT;
			imucf_pkg::ST_SQ_WAIT: if (sq_done) state_d = imucf_pkg::ST_R_GO;
			imucf_pkg::ST_R_GO:    state_d = imucf_pkg::ST_R_WAIT;
			imucf_pkg::ST_R_WAIT:  if (cor_done) state_d = imucf_pkg::ST_P_GO;
			imucf_pkg::ST_P_GO:    state_d = imucf_pkg::ST_P_WAIT;
			imucf_pkg::ST_P_WAIT:  if (cor_done) state_d = imucf_pkg::ST_MUL_RX;
			imucf_pkg::ST_MUL_RX:  state_d = imucf_pkg::ST_MUL_RY;
			imucf_pkg::ST_MUL_RY:  state_d = imucf_pkg::ST_MUL_RZ;
			imucf_pkg::ST_MUL_RZ:  state_d = imucf_pkg::ST_MUL_BR1;
			imucf_pkg::ST_MUL_BR1: state_d = imucf_pkg::ST_MUL_BR2;
			imucf_pkg::ST_MUL_BR2: state_d = imucf_pkg::ST_MUL_BP1;
			imucf_pkg::ST_MUL_BP1: state_d = imucf_pkg::ST_MUL_BP2;
			imucf_pkg::ST_MUL_BP2: state_d = imucf_pkg::ST_FIN;
			imucf_pkg::ST_FIN:     state_d = imucf_pkg::ST_WB;
			imucf_pkg::ST_WB:      if (load) state_d = imucf_pkg::ST_IDLE;
			default:               state_d = imucf_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs: s_tready, unit starts, CORDIC operands and shared multiplier operands
	always_comb begin
		s_tready  = (state_q == imucf_pkg::ST_IDLE);
		sq_start  = (state_q == imucf_pkg::ST_SQ_GO);
		cor_start = (state_q == imucf_pkg::ST_R_GO) || (state_q == imucf_pkg::ST_P_GO);
		if (state_q == imucf_pkg::ST_P_GO) begin
			cor_y = 34'sd0 - $signed({{4{ax_q[15]}}, ax_q, 14'd0});
			cor_x = $signed({4'd0, mag_q});
		end else begin
			cor_y = $signed({{4{ay_q[15]}}, ay_q, 14'd0});
			cor_x = $signed({{4{az_q[15]}}, az_q, 14'd0});
		end
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			imucf_pkg::ST_SQ_A: begin
				mul_a = 33'(ay_q);
				mul_b = 21'(ay_q);
			end
			imucf_pkg::ST_SQ_B: begin
				mul_a = 33'(az_q);
				mul_b = 21'(az_q);
			end
			imucf_pkg::ST_MUL_RX: begin
				mul_a = 33'(gx_q);
				mul_b = $signed({1'b0, ts_q});
			end
			imucf_pkg::ST_MUL_RY: begin
				mul_a = 33'(gy_q);
				mul_b = $signed({1'b0, ts_q});
			end
			imucf_pkg::ST_MUL_RZ: begin
				mul_a = 33'(gz_q);
				mul_b = $signed({1'b0, ts_q});
			end
			imucf_pkg::ST_MUL_BR1: begin
				mul_a = 33'(rint_q);
				mul_b = $signed({4'd0, imucf_pkg::GYRO_WEIGHT});
			end
			imucf_pkg::ST_MUL_BR2: begin
				mul_a = 33'(racc_q);
				mul_b = $signed({4'd0, imucf_pkg::ACC_WEIGHT});
			end
			imucf_pkg::ST_MUL_BP1: begin
				mul_a = 33'(pint_q);
				mul_b = $signed({4'd0, imucf_pkg::GYRO_WEIGHT});
			end
			imucf_pkg::ST_MUL_BP2: begin
				mul_a = 33'(pacc_q);
				mul_b = $signed({4'd0, imucf_pkg::ACC_WEIGHT});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// control registers and angle state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= imucf_pkg::ST_IDLE;
			ts_q       <= imucf_pkg::TIME_STEP_RESET;
			m_tvalid_q <= 1'b0;
			roll_q     <= '0;
			pitch_q    <= '0;
			yaw_q      <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) ts_q <= cfg_data;
			if (load) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
			if (accept && s_tuser[0]) begin
				roll_q  <= '0;
				pitch_q <= '0;
				yaw_q   <= '0;
			end
			if (state_q == imucf_pkg::ST_MUL_BR1) yaw_q <= wrap(integ(yaw_q, prod_q));
			if (state_q == imucf_pkg::ST_MUL_BP1) roll_q <= blend(acc_q, prod_q);
			if (state_q == imucf_pkg::ST_FIN) pitch_q <= blend(acc_q, prod_q);
		end
	end

	// sample capture and intermediate results
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (accept) begin
			ax_q <= s_tdata[15:0];
			ay_q <= s_tdata[31:16];
			az_q <= s_tdata[47:32];
			gx_q <= s_tdata[71:48];
			gy_q <= s_tdata[95:72];
			gz_q <= s_tdata[119:96];
		end
		if (state_q == imucf_pkg::ST_SQ_B || state_q == imucf_pkg::ST_MUL_BR2
			|| state_q == imucf_pkg::ST_MUL_BP2)
			acc_q <= prod_q;
		if (state_q == imucf_pkg::ST_SQ_WAIT && sq_done) mag_q <= sq_root;
		if (state_q == imucf_pkg::ST_R_WAIT && cor_done) racc_q <= cor_angle;
		if (state_q == imucf_pkg::ST_P_WAIT && cor_done) pacc_q <= cor_angle;
		if (state_q == imucf_pkg::ST_MUL_RY) rint_q <= integ(roll_q, prod_q);
		if (state_q == imucf_pkg::ST_MUL_RZ) pint_q <= integ(pitch_q, prod_q);
		if (load) out_q <= {yaw_q, pitch_q, roll_q};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;

	// not ready again right after an item is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("sample accepted back to back");

	// unit completions only where the sequencer waits for them
	a_sqrt_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sq_done |-> (state_q == imucf_pkg::ST_SQ_WAIT))
		else $error("square root finished outside its wait state");

	a_cordic_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cor_done |-> (state_q == imucf_pkg::ST_R_WAIT || state_q == imucf_pkg::ST_P_WAIT))
		else $error("CORDIC finished outside its wait states");

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the complementary roll/pitch/yaw attitude filter.
module tb;

	localparam int          CORDIC_ITERS = 16;
	localparam longint      PI_Q30_C     = 64'sd3373259426;
	localparam longint      PI_Q16_C     = 64'sd205887;
	localparam longint      TWO_PI_Q16_C = 64'sd411775;
	localparam longint      W_GYRO       = 64'sd64225;
	localparam longint      W_ACC        = 64'sd1311;
	localparam logic [19:0] STEP_DEFAULT = 20'd20972;
	localparam int          DRAIN_CYCLES = 200;
	localparam int          STALL_LIMIT  = 20000;

	typedef enum logic [0:0] {CMD_UPDATE = 1'b0, CMD_ZERO = 1'b1} imu_cmd_t;

	typedef struct packed {
		logic signed [23:0] rz;
		logic signed [23:0] ry;
		logic signed [23:0] rx;
		logic signed [15:0] az;
		logic signed [15:0] ay;
		logic signed [15:0] ax;
	} imu_sample_t;

	typedef struct packed {
		logic signed [31:0] yaw;
		logic signed [31:0] pitch;
		logic signed [31:0] roll;
	} attitude_t;

	localparam longint ATAN_TABLE [0:23] = '{
		843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
		16775850, 8388437, 4194282, 2097149, 1048575, 524287,
		262143, 131071, 65535, 32767, 16383, 8191, 4095, 2047,
		1023, 511, 255, 127};

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [119:0] s_tdata;   // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z
	logic [0:0]   s_tuser;   // command
	logic         m_tvalid;
	logic         m_tready;
	logic [95:0]  m_tdata;   // roll_angle, pitch_angle, yaw_angle
	logic         cfg_valid;
	logic         cfg_ready;
	logic [19:0]  cfg_data;

	// predictor state
	logic signed [31:0] roll_q, pitch_q, yaw_q;
	logic [19:0]        step_q;
	attitude_t          pending_angles[$];

	int mismatches;
	int idle_cycles;
	int send_idle_pct;
	int recv_stall_pct;

	imu_complementary_attitude_filter dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	function automatic longint sat_s32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint root_floor(longint n);
		longint res, bit_v;
		res = 0;
		bit_v = 64'sd1 <<< 62;
		while (bit_v > n) bit_v = bit_v >>> 2;
		while (bit_v != 0) begin
			if (n >= res + bit_v) begin
				n = n - (res + bit_v);
				res = (res >>> 1) + bit_v;
			end else begin
				res = res >>> 1;
			end
			bit_v = bit_v >>> 2;
		end
		return res;
	endfunction

	// vectoring-mode arctangent, Q16.16 result
	function automatic longint vector_angle(longint y, longint x);
		longint z, xs, ys;
		z = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			z = (y >= 0) ? PI_Q30_C : -PI_Q30_C;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < CORDIC_ITERS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys; y = y - xs; z = z + ATAN_TABLE[i];
			end else begin
				x = x - ys; y = y + xs; z = z - ATAN_TABLE[i];
			end
		end
		return (z + 8192) >>> 14;
	endfunction

	function automatic longint add_rate(longint angle, longint rate);
		longint stp;
		stp = (rate * longint'(step_q) + (64'sd1 <<< 19)) >>> 20;
		return sat_s32(angle + stp);
	endfunction

	function automatic longint mix_angles(longint angle, longint acc);
		return sat_s32((W_GYRO * angle + W_ACC * acc + 32768) >>> 16);
	endfunction

	// advance the predicted attitude by one accepted item
	function automatic attitude_t predict_attitude(imu_cmd_t cmd, imu_sample_t s);
		longint ax, ay, az, mag, r_acc, p_acc, yw;
		attitude_t a;
		if (cmd == CMD_ZERO) begin
			roll_q = '0; pitch_q = '0; yaw_q = '0;
		end else begin
			ax = longint'(s.ax); ay = longint'(s.ay); az = longint'(s.az);
			mag = root_floor((ay * ay + az * az) <<< 28);
			r_acc = vector_angle(ay * 16384, az * 16384);
			p_acc = vector_angle(-ax * 16384, mag);
			roll_q = 32'(mix_angles(add_rate(longint'(roll_q), longint'(s.rx)), r_acc));
			pitch_q = 32'(mix_angles(add_rate(longint'(pitch_q), longint'(s.ry)), p_acc));
			yw = add_rate(longint'(yaw_q), longint'(s.rz));
			if (yw > PI_Q16_C) yw = yw - TWO_PI_Q16_C;
			else if (yw < -PI_Q16_C) yw = yw + TWO_PI_Q16_C;
			yaw_q = 32'(yw);
		end
		a.roll = roll_q; a.pitch = pitch_q; a.yaw = yaw_q;
		return a;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, $signed(got),
			$signed(want), $realtime);
		mismatches++;
	endtask

	// send one item; s_tvalid stays high until the next call decides otherwise
	task automatic send_sample(imu_cmd_t cmd, imu_sample_t s);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= s;
		do @(posedge clk); while (!s_tready);
		pending_angles.push_back(predict_attitude(cmd, s));
	endtask

	task automatic write_step(logic [19:0] v);
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (pending_angles.size() == 0);
		repeat (100) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		step_q = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic imu_sample_t rand_sample();
		imu_sample_t s;
		s = 120'({$urandom, $urandom, $urandom, $urandom});
		case ($urandom_range(5))
			0: begin s.ax = 16'($signed(4'($urandom))); s.ay = 16'($signed(4'($urandom)));
				s.az = 16'($signed(4'($urandom))); end
			1: begin s.ay = '0; s.az = '0; end
			2: begin s.ax = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
				s.az = $urandom_range(1) ? 16'sh7fff : 16'sh8000; end
			default: ;
		endcase
		if ($urandom_range(2) == 0) begin
			s.rx = 24'($signed(16'($urandom))); s.ry = 24'($signed(16'($urandom)));
			s.rz = 24'($signed(16'($urandom)));
		end
		return s;
	endfunction

	// extremes of every field, both commands, zero vectors and negative z axis
	task automatic test_directed();
		imu_sample_t s;
		s = '0;
		send_sample(CMD_UPDATE, s);
		s = '{rz: 24'sh7fffff, ry: 24'sh7fffff, rx: 24'sh7fffff,
			az: 16'sh7fff, ay: 16'sh7fff, ax: 16'sh7fff};
		send_sample(CMD_UPDATE, s);
		send_sample(CMD_UPDATE, s);   // yaw goes past pi and wraps
		send_sample(CMD_UPDATE, s);
		s = '{rz: 24'sh800000, ry: 24'sh800000, rx: 24'sh800000,
			az: 16'sh8000, ay: 16'sh8000, ax: 16'sh8000};
		for (int i = 0; i < 5; i++) send_sample(CMD_UPDATE, s);
		s.ay = 16'sd100;  s.az = -16'sd200; send_sample(CMD_UPDATE, s);
		s.ay = 16'sd0;    s.az = -16'sd1;   send_sample(CMD_UPDATE, s);
		s.ay = -16'sd50;  s.az = -16'sd50;  send_sample(CMD_UPDATE, s);
		s.ay = 16'sd0;    s.az = 16'sd0;    s.ax = 16'sd0; send_sample(CMD_UPDATE, s);
		s.ax = 16'sd1000; send_sample(CMD_UPDATE, s);
		s.ax = -16'sd1;   send_sample(CMD_UPDATE, s);
		send_sample(CMD_ZERO, s);
		send_sample(CMD_ZERO, '1);
		send_sample(CMD_UPDATE, '1);
	endtask

	// time step extremes, including the zero step that disables integration
	task automatic test_step_extremes();
		logic [19:0] steps [3] = '{20'hfffff, 20'd1, 20'd0};
		foreach (steps[k]) begin
			write_step(steps[k]);
			for (int i = 0; i < 8; i++)
				send_sample($urandom_range(9) == 0 ? CMD_ZERO : CMD_UPDATE, rand_sample());
		end
	endtask

	task automatic test_random(int n, int s_idle, int r_stall);
		send_idle_pct  = s_idle;
		recv_stall_pct = r_stall;
		for (int i = 0; i < n; i++) begin
			if (i % 150 == 0)
				write_step(i % 300 == 0 ? 20'($urandom_range(1, 20'hfffff))
					: 20'($urandom_range(1, 200000)));
			send_sample($urandom_range(19) == 0 ? CMD_ZERO : CMD_UPDATE, rand_sample());
		end
	endtask

	// result checker
	always @(posedge clk) begin
		attitude_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_angles.size() == 0) begin
				$display("unexpected result transaction at %0t", $realtime);
				mismatches++;
			end else begin
				want = pending_angles.pop_front();
				if (got.roll !== want.roll) report("roll_angle", got.roll, want.roll);
				if (got.pitch !== want.pitch) report("pitch_angle", got.pitch, want.pitch);
				if (got.yaw !== want.yaw) report("yaw_angle", got.yaw, want.yaw);
			end
		end
	end

	// receiver back-pressure
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("imu_complementary_attitude_filter verification failed");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		mismatches = 0;
		idle_cycles = 0;
		send_idle_pct = 38;
		recv_stall_pct = 56;
		roll_q = '0; pitch_q = '0; yaw_q = '0;
		step_q = STEP_DEFAULT;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_step_extremes();
		test_random(600, 38, 56);
		test_random(600, 56, 38);
		test_random(550, 0, 0);

		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (pending_angles.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("imu_complementary_attitude_filter verification clean");
		else
			$display("imu_complementary_attitude_filter verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/imucf_pkg.sv
design/imucf_isqrt.sv
design/imucf_cordic.sv
design/imu_complementary_attitude_filter.sv
bench/tb.sv
